// ----- rtl/bbt_pkg.sv -----
// Shared types and constants of the box blur and threshold stream block.
`default_nettype none

package bbt_pkg;

   // Line buffer depth, the widest row that the blur can hold.
   localparam int MAX_WIDTH = 2048;
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int DIM_W = 12;
   localparam int CNT_W = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;

   localparam int CHAN_W = 8;
   localparam int CHANS = 3;
   localparam int LEVEL_W = 8;
   localparam int COLSUM_W = 10;
   localparam int WINSUM_W = 12;
   localparam int NUM_CELLS = 3;

   // Reciprocal of nine for the window sums, exact for every sum below 2^15.
   localparam int DIV9_SHIFT = 16;
   localparam int DIV9_MUL = (1 << DIV9_SHIFT) / 9 + 1;
   localparam int DIV9_MUL_W = 13;
   localparam int PROD_W = WINSUM_W + DIV9_MUL_W;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 12;

   localparam logic [DIM_W-1:0] MIN_DIM = DIM_W'(3);
   localparam logic [DIM_W-1:0] WIDTH_RESET = DIM_W'(640);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);
   localparam logic [LEVEL_W-1:0] LEVEL_RESET = LEVEL_W'(128);
   localparam logic [CHAN_W-1:0] CHAN_WHITE = CHAN_W'(255);
   localparam logic [CHAN_W-1:0] CHAN_BLACK = CHAN_W'(0);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BLUR_ENABLE      = 3'd0,
      CSR_THRESHOLD_ENABLE = 3'd1,
      CSR_THRESHOLD_LEVEL  = 3'd2,
      CSR_FRAME_WIDTH      = 3'd3,
      CSR_FRAME_HEIGHT     = 3'd4
   } csr_index_type;

   // Channel 0 is blue, 1 green, 2 red.
   typedef logic [CHANS-1:0][CHAN_W-1:0] pixel_type;
   typedef logic [CHANS-1:0][COLSUM_W-1:0] colsum_type;
   typedef logic [CHANS-1:0][WINSUM_W-1:0] winsum_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

   typedef struct packed {
      logic             en;
      logic [COL_W-1:0] addr;
      pixel_type        top;
      pixel_type        mid;
   } lb_wr_type;

endpackage

`default_nettype wire

// ----- rtl/bbt_if.sv -----
// Stream and register write channels of the box blur and threshold block.
`default_nettype none

interface bbt_req_if;
   logic                      valid;
   logic                      ready;
   logic [bbt_pkg::CHAN_W-1:0] in_blue;
   logic [bbt_pkg::CHAN_W-1:0] in_green;
   logic [bbt_pkg::CHAN_W-1:0] in_red;

   modport source (output valid, output in_blue, output in_green, output in_red,
                   input ready);
   modport sink (input valid, input in_blue, input in_green, input in_red,
                 output ready);
endinterface

interface bbt_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [bbt_pkg::CHAN_W-1:0] out_blue;
   logic [bbt_pkg::CHAN_W-1:0] out_green;
   logic [bbt_pkg::CHAN_W-1:0] out_red;
   logic                      frame_last;

   modport source (output valid, output out_blue, output out_green, output out_red,
                   output frame_last, input ready);
   modport sink (input valid, input out_blue, input out_green, input out_red,
                 input frame_last, output ready);
endinterface

interface bbt_csr_if;
   logic                           valid;
   logic                           ready;
   logic [bbt_pkg::CSR_INDEX_W-1:0] index;
   logic [bbt_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/bbt_cell.sv -----
// One window column cell: holds a column sum and adds it to the passing total.
`default_nettype none

module bbt_cell (
   input  wire                    clock,
   input  wire                    reset,
   input  bbt_pkg::cell_ctrl_type ctrl,
   input  bbt_pkg::colsum_type    col_in,
   input  bbt_pkg::winsum_type    part_in,
   output bbt_pkg::colsum_type    col_out,
   output bbt_pkg::winsum_type    part_out
);

   bbt_pkg::colsum_type col_ff;

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         col_ff <= '0;
      end else if (ctrl.shift) begin
         col_ff <= col_in;
      end
   end

   assign col_out = col_ff;

   always_comb begin
      for (int k = 0; k < bbt_pkg::CHANS; k++) begin
         part_out[k] = part_in[k] + bbt_pkg::WINSUM_W'(col_ff[k]);
      end
   end

endmodule

`default_nettype wire

// ----- rtl/bbt_line_buffer.sv -----
// Two line buffers holding the two previous rows, one read and one write a cycle.
`default_nettype none

module bbt_line_buffer (
   input  wire                             clock,
   input  wire                             rd_en,
   input  wire [bbt_pkg::COL_W-1:0]        rd_addr,
   input  bbt_pkg::lb_wr_type              wr,
   output bbt_pkg::pixel_type              top_q,
   output bbt_pkg::pixel_type              mid_q
);

   bbt_pkg::pixel_type top_mem [bbt_pkg::MAX_WIDTH];
   bbt_pkg::pixel_type mid_mem [bbt_pkg::MAX_WIDTH];
   bbt_pkg::pixel_type top_q_ff;
   bbt_pkg::pixel_type mid_q_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         top_mem[wr.addr] <= wr.top;
         mid_mem[wr.addr] <= wr.mid;
      end
      if (rd_en) begin
         top_q_ff <= top_mem[rd_addr];
         mid_q_ff <= mid_mem[rd_addr];
      end
   end

   assign top_q = top_q_ff;
   assign mid_q = mid_q_ff;

endmodule

`default_nettype wire

// ----- rtl/box_blur_threshold_stream_core.sv -----
// Top level of the 3x3 box blur and binary threshold pixel stream.
// Throughput: one pixel per cycle; the pipeline stalls only while a result waits.
// Each result passes every pipeline stage and the output register; with the blur
// on, its transaction is the pixel one row and one column below its centre.
// Reset clears the pipeline, the window cells and the counters and loads the
// register defaults; the line buffers need no clearing.
`default_nettype none

module box_blur_threshold_stream_core (
   input  wire          clock,
   input  wire          reset,
   bbt_req_if.sink      req_bus,
   bbt_rsp_if.source    rsp_bus,
   bbt_csr_if.sink      csr_bus
);

   // Configuration registers.
   logic                            blur_en_ff;
   logic                            thr_en_ff;
   logic [bbt_pkg::LEVEL_W-1:0]     level_ff;
   logic [bbt_pkg::DIM_W-1:0]       width_ff;
   logic [bbt_pkg::DIM_W-1:0]       height_ff;
   logic                            restart;

   // Raster position of the next incoming pixel.
   logic [bbt_pkg::COL_W-1:0]       col_ff;
   logic [bbt_pkg::DIM_W-1:0]       row_ff;
   logic [bbt_pkg::COL_W-1:0]       col_in;
   logic [bbt_pkg::DIM_W-1:0]       row_in;
   logic [bbt_pkg::DIM_W-1:0]       width_eff;
   logic [bbt_pkg::DIM_W-1:0]       height_eff;
   logic                            col_end;
   logic                            row_end;

   // Pipeline stages.
   logic                            en;
   logic                            accept;
   bbt_pkg::pixel_type              pix_in;
   logic                            emit_in;
   logic                            last_in;

   logic                            v1_ff, v2_ff, v3_ff, v4_ff;
   bbt_pkg::pixel_type              pix1_ff, pix2_ff, pix3_ff;
   logic                            emit1_ff, emit2_ff, emit3_ff, emit4_ff;
   logic                            last1_ff, last2_ff, last3_ff, last4_ff;
   logic [bbt_pkg::COL_W-1:0]       col1_ff;
   bbt_pkg::winsum_type             sum3_ff;
   bbt_pkg::pixel_type              ch4_ff;

   bbt_pkg::pixel_type              top_q;
   bbt_pkg::pixel_type              mid_q;
   bbt_pkg::lb_wr_type              lb_wr;
   bbt_pkg::colsum_type             colsum1;
   bbt_pkg::cell_ctrl_type          cell_ctrl;
   bbt_pkg::colsum_type             cell_col  [bbt_pkg::NUM_CELLS+1];
   bbt_pkg::winsum_type             cell_part [bbt_pkg::NUM_CELLS+1];
   bbt_pkg::pixel_type              quot3;
   bbt_pkg::pixel_type              thr4;

   // Output register.
   logic                            rsp_valid_ff;
   bbt_pkg::pixel_type              rsp_pix_ff;
   logic                            rsp_last_ff;

   // ---------------------------------------------------------------------
   // Register port. Writes are always taken; a write to either dimension
   // restarts the frame from its first pixel.
   // ---------------------------------------------------------------------
   assign csr_bus.ready = 1'b1;

   always_comb begin
      restart = 1'b0;
      if (csr_bus.valid) begin
         restart = (csr_bus.index == bbt_pkg::CSR_FRAME_WIDTH) ||
                   (csr_bus.index == bbt_pkg::CSR_FRAME_HEIGHT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blur_en_ff <= 1'b1;
         thr_en_ff  <= 1'b1;
         level_ff   <= bbt_pkg::LEVEL_RESET;
         width_ff   <= bbt_pkg::WIDTH_RESET;
         height_ff  <= bbt_pkg::HEIGHT_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            bbt_pkg::CSR_BLUR_ENABLE:      blur_en_ff <= csr_bus.data[0];
            bbt_pkg::CSR_THRESHOLD_ENABLE: thr_en_ff  <= csr_bus.data[0];
            bbt_pkg::CSR_THRESHOLD_LEVEL:  level_ff   <= csr_bus.data[bbt_pkg::LEVEL_W-1:0];
            bbt_pkg::CSR_FRAME_WIDTH:      width_ff   <= csr_bus.data[bbt_pkg::DIM_W-1:0];
            bbt_pkg::CSR_FRAME_HEIGHT:     height_ff  <= csr_bus.data[bbt_pkg::DIM_W-1:0];
            default: begin
               // Indexes beyond the register list are ignored.
            end
         endcase
      end
   end

   // Out-of-range geometry is clamped: rows and columns never fall below three,
   // and a row never exceeds what the line buffers hold.
   always_comb begin
      if (width_ff < bbt_pkg::MIN_DIM) begin
         width_eff = bbt_pkg::MIN_DIM;
      end else if (int'(width_ff) > bbt_pkg::MAX_WIDTH) begin
         width_eff = bbt_pkg::DIM_W'(bbt_pkg::MAX_WIDTH);
      end else begin
         width_eff = width_ff;
      end
      height_eff = (height_ff < bbt_pkg::MIN_DIM) ? bbt_pkg::MIN_DIM : height_ff;
   end

   // ---------------------------------------------------------------------
   // Input side. The whole pipeline advances together unless the output
   // register holds a result that has not been taken.
   // ---------------------------------------------------------------------
   assign en             = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready  = en;
   assign accept         = req_bus.valid && en;

   assign pix_in[0] = req_bus.in_blue;
   assign pix_in[1] = req_bus.in_green;
   assign pix_in[2] = req_bus.in_red;

   assign col_end = (bbt_pkg::CNT_W'(col_ff) == bbt_pkg::CNT_W'(width_eff) - bbt_pkg::CNT_W'(1));
   assign row_end = (row_ff == height_eff - bbt_pkg::DIM_W'(1));
   assign last_in = col_end && row_end;

   // With the blur on, only pixels that complete a full 3x3 window emit.
   assign emit_in = !blur_en_ff ||
                    ((row_ff >= bbt_pkg::DIM_W'(2)) && (col_ff >= bbt_pkg::COL_W'(2)));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + bbt_pkg::DIM_W'(1);
         end else begin
            col_in = col_ff + bbt_pkg::COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------------
   // Line buffers. The column of the accepted pixel is read at once; the
   // same column is rewritten when the pixel leaves the first stage, the
   // middle row moving up and the new pixel becoming the middle row.
   // ---------------------------------------------------------------------
   assign lb_wr.en   = en && v1_ff;
   assign lb_wr.addr = col1_ff;
   assign lb_wr.top  = mid_q;
   assign lb_wr.mid  = pix1_ff;

   bbt_line_buffer u_line_buffer (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .wr      (lb_wr),
      .top_q   (top_q),
      .mid_q   (mid_q)
   );

   // Stage 1: sum the three pixels of the incoming column, per channel.
   always_comb begin
      for (int k = 0; k < bbt_pkg::CHANS; k++) begin
         colsum1[k] = bbt_pkg::COLSUM_W'(top_q[k]) + bbt_pkg::COLSUM_W'(mid_q[k]) +
                      bbt_pkg::COLSUM_W'(pix1_ff[k]);
      end
   end

   // ---------------------------------------------------------------------
   // Window: a chain of column cells. Every pixel that leaves stage 1 shifts
   // its column sum into the first cell, and the running total picks up each
   // cell's sum as it passes along the chain, giving the 3x3 sum.
   // ---------------------------------------------------------------------
   assign cell_ctrl.shift = en && v1_ff;
   assign cell_ctrl.clear = restart;
   assign cell_col[0]     = colsum1;
   assign cell_part[0]    = '0;

   for (genvar i = 0; i < bbt_pkg::NUM_CELLS; i++) begin : g_cell
      bbt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (cell_ctrl),
         .col_in   (cell_col[i]),
         .part_in  (cell_part[i]),
         .col_out  (cell_col[i+1]),
         .part_out (cell_part[i+1])
      );
   end

   // Stage 3: divide each window sum by nine through the reciprocal.
   always_comb begin
      logic [bbt_pkg::PROD_W-1:0] prod;
      for (int k = 0; k < bbt_pkg::CHANS; k++) begin
         prod = bbt_pkg::PROD_W'(sum3_ff[k]) * bbt_pkg::PROD_W'(bbt_pkg::DIV9_MUL);
         quot3[k] = prod[bbt_pkg::DIV9_SHIFT +: bbt_pkg::CHAN_W];
      end
   end

   // Stage 4: the pixel turns white only when every channel is above the level.
   always_comb begin
      logic white;
      white = 1'b1;
      for (int k = 0; k < bbt_pkg::CHANS; k++) begin
         if (!(ch4_ff[k] > level_ff)) begin
            white = 1'b0;
         end
      end
      for (int k = 0; k < bbt_pkg::CHANS; k++) begin
         if (thr_en_ff) begin
            thr4[k] = white ? bbt_pkg::CHAN_WHITE : bbt_pkg::CHAN_BLACK;
         end else begin
            thr4[k] = ch4_ff[k];
         end
      end
   end

   // Stage valid flags and the output valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff        <= accept;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         rsp_valid_ff <= v4_ff && emit4_ff;
      end
   end

   // Stage payloads. Border pixels travel as bubbles and are dropped at the end.
   always_ff @(posedge clock) begin
      if (en) begin
         pix1_ff   <= pix_in;
         emit1_ff  <= emit_in;
         last1_ff  <= last_in;
         col1_ff   <= col_ff;

         pix2_ff   <= pix1_ff;
         emit2_ff  <= emit1_ff;
         last2_ff  <= last1_ff;

         sum3_ff   <= cell_part[bbt_pkg::NUM_CELLS];
         pix3_ff   <= pix2_ff;
         emit3_ff  <= emit2_ff;
         last3_ff  <= last2_ff;

         ch4_ff    <= blur_en_ff ? quot3 : pix3_ff;
         emit4_ff  <= emit3_ff;
         last4_ff  <= last3_ff;

         rsp_pix_ff  <= thr4;
         rsp_last_ff <= last4_ff;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.out_blue   = rsp_pix_ff[0];
   assign rsp_bus.out_green  = rsp_pix_ff[1];
   assign rsp_bus.out_red    = rsp_pix_ff[2];
   assign rsp_bus.frame_last = rsp_last_ff;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the 3x3 box blur and binary threshold pixel stream core.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RUN_LIMIT = 1_000_000;
   localparam int unsigned RANDOM_PIXELS = 430;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned WIN_CELLS = 6;
   localparam int unsigned BOX_CELLS = 9;
   localparam int unsigned MAX_BURST = 16;
   localparam int unsigned DEFAULT_PIXELS = 24;
   localparam int unsigned WIDE_PIXELS = 64;
   localparam logic [bbt_pkg::CSR_INDEX_W-1:0] CSR_UNMAPPED = 3'd7;

   typedef enum {CONTENT_RANDOM, CONTENT_NEAR_LEVEL, CONTENT_EXTREME} content_kind_type;

   typedef struct {
      logic [bbt_pkg::CHAN_W-1:0] blue;
      logic [bbt_pkg::CHAN_W-1:0] green;
      logic [bbt_pkg::CHAN_W-1:0] red;
      logic                       frame_last;
   } out_pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bbt_req_if req_bus ();
   bbt_rsp_if rsp_bus ();
   bbt_csr_if csr_bus ();

   box_blur_threshold_stream_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #10 clock = ~clock;

   // Our own picture of the block: two line buffers, the six trailing window
   // cells, the raster position and the register file.
   bbt_pkg::pixel_type          older_row [bbt_pkg::MAX_WIDTH];
   bbt_pkg::pixel_type          newer_row [bbt_pkg::MAX_WIDTH];
   bbt_pkg::pixel_type          win_cells [WIN_CELLS];
   int unsigned                 col_pos;
   int unsigned                 row_pos;
   logic                        blur_on;
   logic                        thresh_on;
   logic [bbt_pkg::LEVEL_W-1:0] thresh_level;
   logic [bbt_pkg::DIM_W-1:0]   width_reg;
   logic [bbt_pkg::DIM_W-1:0]   height_reg;

   out_pixel_type       expected_pixels [$];
   bbt_pkg::pixel_type  pending_pixels [$];

   int unsigned gap_percent = 0;
   int unsigned stall_percent = 0;
   int unsigned send_gap = 0;
   int unsigned stall_left = 0;
   bbt_pkg::pixel_type next_px;
   out_pixel_type      wanted;

   int unsigned failures = 0;
   int unsigned pixels_sent = 0;
   int unsigned results_seen = 0;
   int unsigned frame_ends_seen = 0;
   int unsigned csr_writes = 0;
   int unsigned cycle_count = 0;

   // Out-of-range widths are clamped to the span the line buffers can hold.
   function automatic int unsigned active_width();
      if (width_reg < bbt_pkg::MIN_DIM) return bbt_pkg::MIN_DIM;
      if (width_reg > bbt_pkg::MAX_WIDTH) return bbt_pkg::MAX_WIDTH;
      return width_reg;
   endfunction

   function automatic int unsigned active_height();
      return (height_reg < bbt_pkg::MIN_DIM) ? bbt_pkg::MIN_DIM : height_reg;
   endfunction

   function automatic void restart_frame();
      col_pos = 0;
      row_pos = 0;
      foreach (win_cells[j]) win_cells[j] = '0;
   endfunction

   function automatic void apply_register(logic [bbt_pkg::CSR_INDEX_W-1:0] index,
                                          logic [bbt_pkg::CSR_DATA_W-1:0] data);
      unique case (index)
         bbt_pkg::CSR_BLUR_ENABLE:      blur_on = data[0];
         bbt_pkg::CSR_THRESHOLD_ENABLE: thresh_on = data[0];
         bbt_pkg::CSR_THRESHOLD_LEVEL:  thresh_level = data[bbt_pkg::LEVEL_W-1:0];
         bbt_pkg::CSR_FRAME_WIDTH: begin
            width_reg = data;
            restart_frame();
         end
         bbt_pkg::CSR_FRAME_HEIGHT: begin
            height_reg = data;
            restart_frame();
         end
         default: ;
      endcase
   endfunction

   // Works out what one accepted pixel produces and advances the raster
   // position. A result, if any, joins the back of the expected queue.
   function automatic void filter_pixel(bbt_pkg::pixel_type cur);
      int unsigned                w;
      int unsigned                h;
      int unsigned                total;
      bbt_pkg::pixel_type         top;
      bbt_pkg::pixel_type         mid;
      logic [bbt_pkg::CHAN_W-1:0] chan [bbt_pkg::CHANS];
      logic                       emit;
      logic                       white;
      logic                       frame_end;
      out_pixel_type              outcome;

      w = active_width();
      h = active_height();
      top = older_row[col_pos];
      mid = newer_row[col_pos];
      frame_end = (row_pos == h - 1) && (col_pos == w - 1);

      if (blur_on) begin
         emit = (row_pos >= 2) && (col_pos >= 2);
         for (int k = 0; k < bbt_pkg::CHANS; k++) begin
            total = top[k] + mid[k] + cur[k];
            for (int j = 0; j < WIN_CELLS; j++) total += win_cells[j][k];
            chan[k] = bbt_pkg::CHAN_W'(total / BOX_CELLS);
         end
      end else begin
         emit = 1'b1;
         for (int k = 0; k < bbt_pkg::CHANS; k++) chan[k] = cur[k];
      end

      if (thresh_on) begin
         white = (chan[0] > thresh_level) && (chan[1] > thresh_level)
               && (chan[2] > thresh_level);
         for (int k = 0; k < bbt_pkg::CHANS; k++) begin
            chan[k] = white ? bbt_pkg::CHAN_WHITE : bbt_pkg::CHAN_BLACK;
         end
      end

      for (int j = 0; j < 3; j++) win_cells[j] = win_cells[j + 3];
      win_cells[3] = top;
      win_cells[4] = mid;
      win_cells[5] = cur;
      older_row[col_pos] = mid;
      newer_row[col_pos] = cur;

      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h) row_pos = 0;
      end

      if (emit) begin
         outcome = '{chan[0], chan[1], chan[2], frame_end};
         expected_pixels.insert(expected_pixels.size(), outcome);
      end
   endfunction

   function automatic void compare_field(string name, logic [bbt_pkg::CHAN_W-1:0] want,
                                         logic [bbt_pkg::CHAN_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endfunction

   function automatic logic [bbt_pkg::CHAN_W-1:0] make_channel(content_kind_type kind);
      int v;
      unique case (kind)
         CONTENT_NEAR_LEVEL: begin
            v = int'(thresh_level) + int'($urandom_range(4)) - 2;
            if (v < 0) v = 0;
            if (v > int'(bbt_pkg::CHAN_WHITE)) v = int'(bbt_pkg::CHAN_WHITE);
            return bbt_pkg::CHAN_W'(v);
         end
         CONTENT_EXTREME: return $urandom_range(1) ? bbt_pkg::CHAN_WHITE : bbt_pkg::CHAN_BLACK;
         default: return bbt_pkg::CHAN_W'($urandom());
      endcase
   endfunction

   // Appends one pixel to the driver's queue of pending transactions.
   function automatic void enqueue_pixel(bbt_pkg::pixel_type px);
      pending_pixels.insert(pending_pixels.size(), px);
   endfunction

   function automatic void queue_pixels(int unsigned count, content_kind_type kind);
      bbt_pkg::pixel_type px;
      repeat (count) begin
         for (int k = 0; k < bbt_pkg::CHANS; k++) px[k] = make_channel(kind);
         enqueue_pixel(px);
      end
   endfunction

   // Keeps the significant low bits and fills the rest of the word with noise,
   // which the block must ignore for the narrow registers.
   function automatic logic [bbt_pkg::CSR_DATA_W-1:0] noisy(int unsigned value,
                                                            int unsigned bits);
      logic [bbt_pkg::CSR_DATA_W-1:0] mask;
      mask = (bbt_pkg::CSR_DATA_W'(1) << bits) - 1'b1;
      return (bbt_pkg::CSR_DATA_W'($urandom()) & ~mask) |
             (bbt_pkg::CSR_DATA_W'(value) & mask);
   endfunction

   function automatic int unsigned pick_idle_percent();
      unique case ($urandom_range(3))
         0: return 0;
         1: return 5;
         2: return 20;
         default: return 40;
      endcase
   endfunction

   // Holds the sender until every pixel is in and every result is out, then
   // lets the pipeline run dry, since a pixel may still be in flight with no
   // result to show for it.
   task automatic wait_until_idle();
      while (pending_pixels.size() != 0 || req_bus.valid || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [bbt_pkg::CSR_INDEX_W-1:0] index,
                                 logic [bbt_pkg::CSR_DATA_W-1:0] data);
      wait_until_idle();
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      apply_register(index, data);
      csr_writes++;
      csr_bus.valid <= 1'b0;
   endtask

   task automatic set_stages(logic blur, logic thresh, logic [bbt_pkg::LEVEL_W-1:0] level);
      write_register(bbt_pkg::CSR_BLUR_ENABLE, noisy(blur, 1));
      write_register(bbt_pkg::CSR_THRESHOLD_ENABLE, noisy(thresh, 1));
      write_register(bbt_pkg::CSR_THRESHOLD_LEVEL, noisy(level, bbt_pkg::LEVEL_W));
   endtask

   // Pixel driver. A transaction completes on an edge where valid and ready
   // are both high; the accepted pixel goes straight into the predictor. The
   // next pixel, or a random gap, follows.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            filter_pixel({req_bus.in_red, req_bus.in_green, req_bus.in_blue});
            pixels_sent++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending_pixels.size() != 0) begin
               next_px = pending_pixels.pop_front();
               req_bus.valid    <= 1'b1;
               req_bus.in_blue  <= next_px[0];
               req_bus.in_green <= next_px[1];
               req_bus.in_red   <= next_px[2];
               if ($urandom_range(99) < gap_percent) send_gap = $urandom_range(1, MAX_BURST);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor. Every result transaction is matched against the oldest
   // expected pixel; ready is dropped in random bursts to exercise back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (expected_pixels.size() == 0) begin
               $error("Unexpected result transaction: blue %0d green %0d red %0d frame_last %0d",
                      rsp_bus.out_blue, rsp_bus.out_green, rsp_bus.out_red,
                      rsp_bus.frame_last);
               failures++;
            end else begin
               wanted = expected_pixels.pop_front();
               compare_field("out_blue", wanted.blue, rsp_bus.out_blue);
               compare_field("out_green", wanted.green, rsp_bus.out_green);
               compare_field("out_red", wanted.red, rsp_bus.out_red);
               compare_field("frame_last", wanted.frame_last, rsp_bus.frame_last);
               if (wanted.frame_last) frame_ends_seen++;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if ($urandom_range(99) < stall_percent) begin
            stall_left = $urandom_range(MAX_BURST - 1);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Watchdog: a hung handshake must not leave the run spinning for ever.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= RUN_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding.",
                  cycle_count, expected_pixels.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int unsigned                 random_pixels;
      int unsigned                 count;
      int unsigned                 frame_px;
      content_kind_type            kind;
      logic [bbt_pkg::LEVEL_W-1:0] level;
      logic                        final_stretch;

      random_pixels = 0;
      req_bus.valid    = 1'b0;
      req_bus.in_blue  = '0;
      req_bus.in_green = '0;
      req_bus.in_red   = '0;
      rsp_bus.ready    = 1'b0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = '0;
      csr_bus.data     = '0;

      blur_on      = 1'b1;
      thresh_on    = 1'b1;
      thresh_level = bbt_pkg::LEVEL_RESET;
      width_reg    = bbt_pkg::WIDTH_RESET;
      height_reg   = bbt_pkg::HEIGHT_RESET;
      restart_frame();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // The register defaults are used untouched first: blur and threshold on,
      // level 128, 640 pixels a row. The first row holds no interior pixel, so
      // nothing may come out.
      gap_percent = 20;
      stall_percent = 20;
      queue_pixels(DEFAULT_PIXELS, CONTENT_NEAR_LEVEL);
      wait_until_idle();

      // Both stages off on a 3x3 frame; widths and heights below the minimum
      // act as three. Fixed bit patterns check the straight path.
      set_stages(1'b0, 1'b0, bbt_pkg::LEVEL_RESET);
      write_register(bbt_pkg::CSR_FRAME_WIDTH, '0);
      write_register(bbt_pkg::CSR_FRAME_HEIGHT, bbt_pkg::DIM_W'(1));
      enqueue_pixel(bbt_pkg::pixel_type'({8'h00, 8'h00, 8'h00}));
      enqueue_pixel(bbt_pkg::pixel_type'({8'hFF, 8'hFF, 8'hFF}));
      enqueue_pixel(bbt_pkg::pixel_type'({8'h55, 8'hAA, 8'h55}));
      enqueue_pixel(bbt_pkg::pixel_type'({8'hAA, 8'h55, 8'hAA}));
      enqueue_pixel(bbt_pkg::pixel_type'({8'h01, 8'h80, 8'hFE}));
      queue_pixels(4, CONTENT_RANDOM);
      wait_until_idle();

      // Threshold alone at its extreme levels and at the default; a channel must
      // strictly exceed the level, and all three must do so for white.
      set_stages(1'b0, 1'b1, '0);
      enqueue_pixel(bbt_pkg::pixel_type'({8'h00, 8'h00, 8'h00}));
      enqueue_pixel(bbt_pkg::pixel_type'({8'h01, 8'h01, 8'h01}));
      enqueue_pixel(bbt_pkg::pixel_type'({8'h01, 8'h00, 8'h01}));
      wait_until_idle();
      write_register(bbt_pkg::CSR_THRESHOLD_LEVEL,
                     noisy(bbt_pkg::CHAN_WHITE, bbt_pkg::LEVEL_W));
      enqueue_pixel(bbt_pkg::pixel_type'({8'hFF, 8'hFF, 8'hFF}));
      wait_until_idle();
      write_register(bbt_pkg::CSR_THRESHOLD_LEVEL,
                     noisy(bbt_pkg::LEVEL_RESET, bbt_pkg::LEVEL_W));
      enqueue_pixel(bbt_pkg::pixel_type'({8'h80, 8'h80, 8'h80}));
      enqueue_pixel(bbt_pkg::pixel_type'({8'h81, 8'h81, 8'h81}));
      enqueue_pixel(bbt_pkg::pixel_type'({8'h81, 8'h81, 8'h80}));
      wait_until_idle();

      // Blur alone on the smallest frame: one interior pixel, flagged as the
      // frame's last. All-white must stay white, all-black stay black.
      set_stages(1'b1, 1'b0, bbt_pkg::LEVEL_RESET);
      write_register(bbt_pkg::CSR_FRAME_WIDTH, bbt_pkg::DIM_W'(2));
      write_register(bbt_pkg::CSR_FRAME_HEIGHT, bbt_pkg::DIM_W'(2));
      repeat (9) enqueue_pixel(bbt_pkg::pixel_type'({bbt_pkg::CHAN_WHITE,
                                                     bbt_pkg::CHAN_WHITE,
                                                     bbt_pkg::CHAN_WHITE}));
      repeat (9) enqueue_pixel(bbt_pkg::pixel_type'({bbt_pkg::CHAN_BLACK,
                                                     bbt_pkg::CHAN_BLACK,
                                                     bbt_pkg::CHAN_BLACK}));
      wait_until_idle();

      // An unmapped register index in the middle of a frame must not restart it.
      set_stages(1'b1, 1'b1, bbt_pkg::LEVEL_RESET);
      queue_pixels(4, CONTENT_NEAR_LEVEL);
      write_register(CSR_UNMAPPED, '1);
      queue_pixels(5, CONTENT_NEAR_LEVEL);
      wait_until_idle();

      // Widest frame: an oversized width clamps to the line buffer depth. With
      // both stages off every pixel of the first row passes straight through,
      // and none of them may be flagged as the frame's last.
      gap_percent = 5;
      stall_percent = 5;
      set_stages(1'b0, 1'b0, bbt_pkg::LEVEL_RESET);
      write_register(bbt_pkg::CSR_FRAME_WIDTH, '1);
      write_register(bbt_pkg::CSR_FRAME_HEIGHT, '0);
      queue_pixels(WIDE_PIXELS, CONTENT_RANDOM);
      wait_until_idle();

      // Tallest frame, only its first rows.
      set_stages(1'b1, 1'b1, bbt_pkg::LEVEL_RESET);
      write_register(bbt_pkg::CSR_FRAME_WIDTH, bbt_pkg::MIN_DIM);
      write_register(bbt_pkg::CSR_FRAME_HEIGHT, '1);
      queue_pixels(40, CONTENT_EXTREME);
      wait_until_idle();

      // Random phases. Most are whole frames of small geometry with random
      // content; some stop part-way, and some keep the old geometry so that
      // the enables change in the middle of a frame. Idling stops in the final
      // stretch.
      while (random_pixels < RANDOM_PIXELS) begin
         final_stretch = random_pixels >= RANDOM_PIXELS * 5 / 6;
         gap_percent = final_stretch ? 0 : pick_idle_percent();
         stall_percent = final_stretch ? 0 : pick_idle_percent();

         if ($urandom_range(3) == 0) level = $urandom_range(1) ? bbt_pkg::CHAN_WHITE : '0;
         else level = bbt_pkg::LEVEL_W'($urandom_range(255));
         set_stages($urandom_range(1), $urandom_range(1), level);

         if ($urandom_range(9) < 7) begin
            write_register(bbt_pkg::CSR_FRAME_WIDTH, ($urandom_range(9) == 0) ?
                           bbt_pkg::DIM_W'($urandom_range(2)) :
                           bbt_pkg::DIM_W'($urandom_range(3, 10)));
            write_register(bbt_pkg::CSR_FRAME_HEIGHT, ($urandom_range(9) == 0) ?
                           bbt_pkg::DIM_W'($urandom_range(2)) :
                           bbt_pkg::DIM_W'($urandom_range(3, 7)));
         end

         kind = content_kind_type'($urandom_range(2));
         frame_px = active_width() * active_height();
         if ($urandom_range(9) < 8) count = frame_px * $urandom_range(1, 2);
         else count = $urandom_range(1, frame_px - 1);
         queue_pixels(count, kind);
         random_pixels += count;
         wait_until_idle();
      end

      $display("Sent %0d pixel transactions and checked %0d results (%0d frame ends)",
               pixels_sent, results_seen, frame_ends_seen);
      $display("across %0d register writes, both stages on and off, in %0d cycles.",
               csr_writes, cycle_count);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
